// ===== sv/irpcr_pkg.sv =====
// Shared types and constants of the infrared pulse capture and replay core.
// Depends on nothing; the core refers to it by scoped names, the testbench imports it.
package irpcr_pkg;

	localparam int MAX_SEGMENTS = 512;
	localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = SEG_AW + 1;
	localparam int TICK_W       = 16;
	localparam int MINSEG_W     = 10;
	localparam int CARR_W       = 8;
	localparam int PADDR_W      = 4;
	localparam int PDATA_W      = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_MIN_SEG = 2'd1;
	localparam logic [1:0] REG_CARRIER = 2'd2;

	localparam logic [TICK_W-1:0]   TIMEOUT_RST = 16'd51456;
	localparam logic [MINSEG_W-1:0] MIN_SEG_RST = 10'd16;
	localparam logic [CARR_W-1:0]   CARRIER_RST = 8'd12;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_CAPT = 2'd2,
		PH_PLAY = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_ARM  = 2'd1,
		CMD_PLAY = 2'd2
	} cmd_t;

	// One stored segment: level and length in ticks.
	typedef struct packed {
		logic              lvl;
		logic [TICK_W-1:0] dur;
	} seg_t;

	localparam int SEG_W = $bits(seg_t);

	typedef struct packed {
		logic             ir_out;
		phase_t           phase;
		logic             capture_done;
		logic             capture_discarded;
		logic [CNT_W-1:0] segment_count;
	} res_t;

endpackage

// ===== sv/irpcr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for the segment store of the capture and replay core.
module irpcr_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/ir_pulse_capture_replay_core.sv =====
// Top level of the infrared pulse capture and replay core.
// Depends on irpcr_pkg and on irpcr_ram for the segment store.
//
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+---------------------------------------------
//  input    | in_valid / in_stall      | cmd, ir_in
//  output   | out_valid / out_stall    | ir_out, phase, capture_done,
//           |                          | capture_discarded, segment_count
//  config   | psel/penable/pwrite/...  | timeout_ticks, min_segments, carrier_half_period
//
// Unless stalled, the core takes one item per clock and registers its result once it is
// accepted. The rate is set by the single read port of the segment memory: its read
// address is steered from the next replay index, so the entry for the segment in play
// always sits on the registered read data when the following item arrives.
// A two-entry output buffer (output register plus skid register) lets an item be
// accepted while a result waits; in_stall rises only once both entries are full.
// Reset clears all control state and loads the register reset values. The segment
// memory is not cleared: replay only ever reads entries written by the kept capture.
module ir_pulse_capture_replay_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         cmd,
	input  logic                               ir_in,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               ir_out,
	output logic [1:0]                         phase,
	output logic                               capture_done,
	output logic                               capture_discarded,
	output logic [irpcr_pkg::CNT_W-1:0]        segment_count,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [irpcr_pkg::PADDR_W-1:0]      paddr,
	input  logic [irpcr_pkg::PDATA_W-1:0]      pwdata,
	output logic [irpcr_pkg::PDATA_W-1:0]      prdata,
	output logic                               pready
);

	// Configuration registers.
	logic [irpcr_pkg::TICK_W-1:0]   timeout_q;
	logic [irpcr_pkg::MINSEG_W-1:0] min_seg_q;
	logic [irpcr_pkg::CARR_W-1:0]   carrier_q;

	// Scalar state. The phase register is the controller's state.
	irpcr_pkg::phase_t              phase_q, phase_d;
	logic [irpcr_pkg::TICK_W-1:0]   tick_q, tick_d;
	logic [irpcr_pkg::CNT_W-1:0]    seg_total_q, seg_total_d;
	logic [irpcr_pkg::SEG_AW-1:0]   rix_q, rix_d;
	logic [irpcr_pkg::CARR_W-1:0]   carr_q, carr_d;
	logic                           outlvl_q, outlvl_d;
	logic                           prev_in_q, prev_in_d;

	// Output buffer: main register and skid register.
	logic                           out_valid_q, skid_valid_q;
	irpcr_pkg::res_t                out_q, skid_q, res;

	// Segment memory access.
	logic                           wr_en;
	irpcr_pkg::seg_t                wr_seg, rd_seg;

	// Step helpers.
	logic                           in_acc, out_take, arm_now;
	logic                           drive, done, dropped;
	logic [irpcr_pkg::TICK_W:0]     tick_inc;
	logic [irpcr_pkg::TICK_W-1:0]   tick_sat;
	logic [irpcr_pkg::CARR_W:0]     carr_inc;
	logic [irpcr_pkg::CNT_W-1:0]    rix_inc;

	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && !skid_valid_q;
	assign out_take = out_valid_q && !out_stall;

	// ------------------------------------------------------------------
	// Configuration port. Register i sits at byte address 4*i; pready is
	// tied high so every access completes in its access cycle.
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= irpcr_pkg::TIMEOUT_RST;
			min_seg_q <= irpcr_pkg::MIN_SEG_RST;
			carrier_q <= irpcr_pkg::CARRIER_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				irpcr_pkg::REG_TIMEOUT: timeout_q <= pwdata[irpcr_pkg::TICK_W-1:0];
				irpcr_pkg::REG_MIN_SEG: min_seg_q <= pwdata[irpcr_pkg::MINSEG_W-1:0];
				irpcr_pkg::REG_CARRIER: carrier_q <= pwdata[irpcr_pkg::CARR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			irpcr_pkg::REG_TIMEOUT: prdata = irpcr_pkg::PDATA_W'(timeout_q);
			irpcr_pkg::REG_MIN_SEG: prdata = irpcr_pkg::PDATA_W'(min_seg_q);
			irpcr_pkg::REG_CARRIER: prdata = irpcr_pkg::PDATA_W'(carrier_q);
			default:                prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Segment memory. Capture writes the ending segment at the current
	// segment total. The read address follows the next replay index, so
	// rd_seg always holds the entry at rix_q. Capture and replay never run
	// together, so a read never meets a write to the same entry in flight.
	// ------------------------------------------------------------------
	assign wr_seg.lvl = prev_in_q;
	assign wr_seg.dur = tick_q;

	irpcr_ram #(
		.WIDTH (irpcr_pkg::SEG_W),
		.DEPTH (irpcr_pkg::MAX_SEGMENTS)
	) u_seg_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (seg_total_q[irpcr_pkg::SEG_AW-1:0]),
		.wr_data (wr_seg),
		.rd_addr (rix_d),
		.rd_data (rd_seg)
	);

	// ------------------------------------------------------------------
	// Per-item step: next state and the result of the accepted item.
	// An arm command, an overflow and a too-short capture all re-arm; they
	// raise arm_now and share the re-arm assignments at the end.
	// ------------------------------------------------------------------
	always_comb begin
		phase_d     = phase_q;
		tick_d      = tick_q;
		seg_total_d = seg_total_q;
		rix_d       = rix_q;
		carr_d      = carr_q;
		outlvl_d    = outlvl_q;
		prev_in_d   = prev_in_q;
		drive       = 1'b1;
		done        = 1'b0;
		dropped     = 1'b0;
		wr_en       = 1'b0;
		arm_now     = 1'b0;
		tick_inc    = {1'b0, tick_q} + 1'b1;
		tick_sat    = (tick_q == '1) ? tick_q : tick_inc[irpcr_pkg::TICK_W-1:0];
		carr_inc    = {1'b0, carr_q} + 1'b1;
		rix_inc     = {1'b0, rix_q} + 1'b1;

		if (in_acc) begin
			prev_in_d = ir_in;
			priority if (cmd == irpcr_pkg::CMD_ARM) begin
				arm_now = 1'b1;
			end else if (cmd == irpcr_pkg::CMD_PLAY && phase_q == irpcr_pkg::PH_IDLE
					&& seg_total_q != '0) begin
				phase_d  = irpcr_pkg::PH_PLAY;
				rix_d    = '0;
				tick_d   = '0;
				carr_d   = '0;
				outlvl_d = 1'b1;
			end else begin
				unique case (phase_q)
					irpcr_pkg::PH_IDLE: ;
					irpcr_pkg::PH_WAIT: begin
						if (prev_in_q && !ir_in) begin
							phase_d = irpcr_pkg::PH_CAPT;
							tick_d  = irpcr_pkg::TICK_W'(1);
						end
					end
					irpcr_pkg::PH_CAPT: begin
						if (ir_in != prev_in_q) begin
							if (seg_total_q >= irpcr_pkg::CNT_W'(irpcr_pkg::MAX_SEGMENTS)) begin
								arm_now = 1'b1;
								dropped = 1'b1;
							end else begin
								wr_en       = 1'b1;
								seg_total_d = seg_total_q + 1'b1;
								tick_d      = irpcr_pkg::TICK_W'(1);
							end
						end else begin
							tick_d = tick_sat;
							if (ir_in && tick_sat >= timeout_q) begin
								if (seg_total_q >= min_seg_q) begin
									phase_d = irpcr_pkg::PH_IDLE;
									tick_d  = '0;
									done    = 1'b1;
								end else begin
									arm_now = 1'b1;
									dropped = 1'b1;
								end
							end
						end
					end
					irpcr_pkg::PH_PLAY: begin
						if (!rd_seg.lvl) begin
							drive  = outlvl_q;
							carr_d = carr_inc[irpcr_pkg::CARR_W-1:0];
							if (carr_inc >= {1'b0, carrier_q}) begin
								carr_d   = '0;
								outlvl_d = !outlvl_q;
							end
						end else begin
							outlvl_d = 1'b1;
						end
						tick_d = tick_inc[irpcr_pkg::TICK_W-1:0];
						if (tick_inc >= {1'b0, rd_seg.dur}) begin
							tick_d   = '0;
							carr_d   = '0;
							outlvl_d = 1'b1;
							if (rix_inc >= seg_total_q) begin
								phase_d = irpcr_pkg::PH_IDLE;
								rix_d   = '0;
							end else begin
								rix_d = rix_inc[irpcr_pkg::SEG_AW-1:0];
							end
						end
					end
				endcase
			end

			if (arm_now) begin
				phase_d     = irpcr_pkg::PH_WAIT;
				seg_total_d = '0;
				tick_d      = '0;
				rix_d       = '0;
				carr_d      = '0;
				outlvl_d    = 1'b1;
			end
		end

		res.ir_out            = drive;
		res.phase             = phase_d;
		res.capture_done      = done;
		res.capture_discarded = dropped;
		res.segment_count     = seg_total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= irpcr_pkg::PH_IDLE;
			tick_q      <= '0;
			seg_total_q <= '0;
			rix_q       <= '0;
			carr_q      <= '0;
			outlvl_q    <= 1'b1;
			prev_in_q   <= 1'b1;
		end else begin
			phase_q     <= phase_d;
			tick_q      <= tick_d;
			seg_total_q <= seg_total_d;
			rix_q       <= rix_d;
			carr_q      <= carr_d;
			outlvl_q    <= outlvl_d;
			prev_in_q   <= prev_in_d;
		end
	end

	// ------------------------------------------------------------------
	// Output buffer. The main register refills from the skid register
	// first, then from a new item; a new item that finds the main register
	// held goes to the skid register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_acc;
			end
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_acc) begin
				out_q <= res;
			end
		end else if (in_acc) begin
			skid_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign ir_out            = out_q.ir_out;
	assign phase             = out_q.phase;
	assign capture_done      = out_q.capture_done;
	assign capture_discarded = out_q.capture_discarded;
	assign segment_count     = out_q.segment_count;

endmodule

// ===== dv/tb_ir_pulse_capture_replay_core.sv =====
// Self-checking testbench for ir_pulse_capture_replay_core: tick-by-tick stimulus, a
// cycle-accurate predictor of the recorder and player, and field-wise result checks.
// Depends on irpcr_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_ir_pulse_capture_replay_core;

	import irpcr_pkg::*;

	// cmd value with no meaning; the core must treat it as a plain tick.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Results that can be read straight off the spec, used by the directed table.
	localparam res_t RES_IDLE_EMPTY = '{ir_out: 1'b1, phase: PH_IDLE, capture_done: 1'b0,
		capture_discarded: 1'b0, segment_count: '0};
	localparam res_t RES_ARMED = '{ir_out: 1'b1, phase: PH_WAIT, capture_done: 1'b0,
		capture_discarded: 1'b0, segment_count: '0};
	localparam res_t RES_FIRST_SEG = '{ir_out: 1'b1, phase: PH_CAPT, capture_done: 1'b0,
		capture_discarded: 1'b0, segment_count: '0};

	// One row of the directed table. Where typed is set, want is the expected result;
	// otherwise the predictor supplies it.
	typedef struct packed {
		logic [1:0] op;
		logic       level;
		logic       typed;
		res_t       want;
	} stim_row_t;

	// Clock, reset and all block inputs start at known values.
	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          cmd      = CMD_TICK;
	logic                ir_in    = 1'b1;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                ir_out;
	logic [1:0]          phase;
	logic                capture_done;
	logic                capture_discarded;
	logic [CNT_W-1:0]    segment_count;
	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [PADDR_W-1:0]  paddr   = '0;
	logic [PDATA_W-1:0]  pwdata  = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// Idle percentages of the two sides, changed between phases of the run.
	int send_idle = 33;
	int recv_idle = 65;

	int items_sent   = 0;
	int results_seen = 0;
	int error_count  = 0;

	res_t pending_results [$];

	// Predictor state. Declared with its reset values, since reset happens once.
	logic [TICK_W-1:0]   cfg_timeout = TIMEOUT_RST;
	logic [MINSEG_W-1:0] cfg_min_seg = MIN_SEG_RST;
	logic [CARR_W-1:0]   cfg_carrier = CARRIER_RST;
	phase_t              ph_now        = PH_IDLE;
	logic [TICK_W-1:0]   seg_ticks     = '0;
	logic [CNT_W-1:0]    rec_count     = '0;
	logic [TICK_W-1:0]   rec_dur [MAX_SEGMENTS];
	logic                rec_lvl [MAX_SEGMENTS];
	logic [CNT_W-1:0]    play_idx      = '0;
	logic [CARR_W-1:0]   carrier_ticks = '0;
	logic                carrier_lvl   = 1'b1;
	logic                last_level    = 1'b1;

	// Directed part: reset values, the ignored replay request, the unused command,
	// edge detection only on a falling edge, segment ends, and arming from idle and capture.
	stim_row_t directed_rows [21] = '{
		'{CMD_TICK,   1'b1, 1'b1, RES_IDLE_EMPTY},
		'{CMD_PLAY,   1'b1, 1'b1, RES_IDLE_EMPTY},
		'{CMD_UNUSED, 1'b0, 1'b1, RES_IDLE_EMPTY},
		'{CMD_ARM,    1'b0, 1'b1, RES_ARMED},
		'{CMD_TICK,   1'b0, 1'b1, RES_ARMED},
		'{CMD_TICK,   1'b1, 1'b1, RES_ARMED},
		'{CMD_TICK,   1'b0, 1'b1, RES_FIRST_SEG},
		'{CMD_TICK,   1'b0, 1'b0, RES_IDLE_EMPTY},
		'{CMD_TICK,   1'b1, 1'b0, RES_IDLE_EMPTY},
		'{CMD_TICK,   1'b0, 1'b0, RES_IDLE_EMPTY},
		'{CMD_UNUSED, 1'b0, 1'b0, RES_IDLE_EMPTY},
		'{CMD_PLAY,   1'b1, 1'b0, RES_IDLE_EMPTY},
		'{CMD_TICK,   1'b1, 1'b0, RES_IDLE_EMPTY},
		'{CMD_ARM,    1'b1, 1'b1, RES_ARMED},
		'{CMD_TICK,   1'b1, 1'b1, RES_ARMED},
		'{CMD_TICK,   1'b0, 1'b1, RES_FIRST_SEG},
		'{CMD_ARM,    1'b0, 1'b1, RES_ARMED},
		'{CMD_TICK,   1'b1, 1'b1, RES_ARMED},
		'{CMD_TICK,   1'b0, 1'b1, RES_FIRST_SEG},
		'{CMD_TICK,   1'b1, 1'b0, RES_IDLE_EMPTY},
		'{CMD_TICK,   1'b0, 1'b0, RES_IDLE_EMPTY}
	};

	ir_pulse_capture_replay_core uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.cmd               (cmd),
		.ir_in             (ir_in),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.ir_out            (ir_out),
		.phase             (phase),
		.capture_done      (capture_done),
		.capture_discarded (capture_discarded),
		.segment_count     (segment_count),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The run should finish well inside this; a hang ends here.
	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	// Every error goes through here. Only the first few are printed so that a badly
	// broken core does not flood the log, but all of them are counted.
	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= 40) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
	endtask

	// Arming clears the recording and the player and waits for a falling edge.
	function automatic void rearm_recorder();
		ph_now        = PH_WAIT;
		rec_count     = '0;
		seg_ticks     = '0;
		play_idx      = '0;
		carrier_ticks = '0;
		carrier_lvl   = 1'b1;
	endfunction

	// Advances the predictor by one accepted tick and returns the result the core
	// must deliver for it.
	function automatic res_t predict_tick(input logic [1:0] op, input logic level);
		res_t              r;
		logic [SEG_AW-1:0] slot;
		r        = RES_IDLE_EMPTY;
		r.ir_out = 1'b1;
		if (op == CMD_ARM) begin
			rearm_recorder();
		end else if (op == CMD_PLAY && ph_now == PH_IDLE && rec_count != 0) begin
			ph_now        = PH_PLAY;
			play_idx      = '0;
			seg_ticks     = '0;
			carrier_ticks = '0;
			carrier_lvl   = 1'b1;
		end else if (ph_now == PH_WAIT) begin
			// The first segment starts on a falling edge and already counts one tick.
			if (last_level && !level) begin
				ph_now    = PH_CAPT;
				seg_ticks = TICK_W'(1);
			end
		end else if (ph_now == PH_CAPT) begin
			if (level != last_level) begin
				if (rec_count >= MAX_SEGMENTS) begin
					// No room for the segment that just ended: drop and re-arm.
					rearm_recorder();
					r.capture_discarded = 1'b1;
				end else begin
					rec_dur[rec_count] = seg_ticks;
					rec_lvl[rec_count] = last_level;
					rec_count++;
					seg_ticks = TICK_W'(1);
				end
			end else begin
				if (seg_ticks != '1) begin
					seg_ticks++;
				end
				// Only a long enough high level ends the capture; it is not stored.
				if (level && seg_ticks >= cfg_timeout) begin
					if (rec_count >= cfg_min_seg) begin
						ph_now         = PH_IDLE;
						seg_ticks      = '0;
						r.capture_done = 1'b1;
					end else begin
						rearm_recorder();
						r.capture_discarded = 1'b1;
					end
				end
			end
		end else if (ph_now == PH_PLAY) begin
			slot = play_idx[SEG_AW-1:0];
			if (!rec_lvl[slot]) begin
				// Low segments go out as a carrier that starts high.
				r.ir_out = carrier_lvl;
				carrier_ticks++;
				if (carrier_ticks >= cfg_carrier) begin
					carrier_ticks = '0;
					carrier_lvl   = !carrier_lvl;
				end
			end else begin
				carrier_lvl = 1'b1;
			end
			seg_ticks++;
			if (seg_ticks >= rec_dur[slot]) begin
				play_idx++;
				seg_ticks     = '0;
				carrier_ticks = '0;
				carrier_lvl   = 1'b1;
				if (play_idx >= rec_count) begin
					ph_now   = PH_IDLE;
					play_idx = '0;
				end
			end
		end
		last_level      = level;
		r.phase         = ph_now;
		r.segment_count = rec_count;
		return r;
	endfunction

	// Offers one item and waits until the core takes it. Gaps are inserted before the
	// item at the sender's idle rate. The expectation is queued at the accepting edge.
	task automatic send_item(input logic [1:0] op, input logic level,
			input logic typed = 1'b0, input res_t want = RES_IDLE_EMPTY);
		res_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		ir_in    <= level;
		do @(posedge clk); while (in_stall);
		predicted = predict_tick(op, level);
		pending_results.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	// Stops offering items and waits until every result has come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Writes one register through the APB port and reads it back.
	task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] readback;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_TIMEOUT: cfg_timeout = value[TICK_W-1:0];
			REG_MIN_SEG: cfg_min_seg = value[MINSEG_W-1:0];
			REG_CARRIER: cfg_carrier = value[CARR_W-1:0];
			default: ;
		endcase
		// Read setup cycle follows directly with psel still high.
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback !== value) begin
			report_error($sformatf("register %0d reads %0h, wrote %0h", idx, readback, value));
		end
	endtask

	task automatic set_config(input int timeout, input int min_seg, input int half_period);
		write_reg(REG_TIMEOUT, timeout);
		write_reg(REG_MIN_SEG, min_seg);
		write_reg(REG_CARRIER, half_period);
	endtask

	// Mostly a plain tick, now and then a command that the current phase must treat
	// as one (replay request while busy, or the unused code).
	function automatic logic [1:0] plain_cmd();
		if ($urandom_range(0, 29) != 0) begin
			return CMD_TICK;
		end
		return $urandom_range(0, 1) ? CMD_PLAY : CMD_UNUSED;
	endfunction

	// Plays back the recording, with random receiver levels that replay must ignore
	// and a rare arm command that aborts it.
	task automatic replay_session();
		int n;
		send_item(CMD_PLAY, 1'($urandom_range(0, 1)));
		n = 0;
		while (ph_now == PH_PLAY && n < 200000) begin
			if ($urandom_range(0, 499) == 0) begin
				send_item(CMD_ARM, 1'b1);
			end else begin
				send_item(plain_cmd(), 1'($urandom_range(0, 1)));
			end
			n++;
		end
	endtask

	// A well-formed capture: arm, idle high, then nseg alternating segments starting
	// low, then high until the timeout. High segments stay below the timeout so that
	// they do not end the capture early. The predictor's phase tells when the capture
	// is over, so overflow and too-short captures end the session as well. A kept
	// capture is played back straight away.
	task automatic capture_session(input int nseg, input int long_len,
			input bit saturate_first);
		int   seg_len;
		int   n;
		logic level;
		send_item(CMD_ARM, 1'($urandom_range(0, 1)));
		repeat ($urandom_range(1, 3)) send_item(plain_cmd(), 1'b1);
		for (int i = 0; i < nseg; i++) begin
			level = i[0];
			if (saturate_first && i == 0) begin
				// Longer than the 16-bit length can hold.
				seg_len = 66000;
			end else if ($urandom_range(0, 19) == 0) begin
				seg_len = $urandom_range(1, long_len);
			end else begin
				seg_len = $urandom_range(1, 6);
			end
			if (level && seg_len >= int'(cfg_timeout)) begin
				seg_len = int'(cfg_timeout) - 1;
			end
			repeat (seg_len) send_item(plain_cmd(), level);
			if (ph_now != PH_CAPT) begin
				break;
			end
		end
		n = 0;
		while (ph_now == PH_CAPT && n < 70000) begin
			send_item(plain_cmd(), 1'b1);
			n++;
		end
		if (ph_now == PH_IDLE && rec_count != 0) begin
			replay_session();
		end
	endtask

	// Random commands and random levels, in whatever phase the core is in.
	task automatic noise_burst(input int count);
		repeat (count) begin
			send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
		end
	endtask

	// The receiver stalls at its idle rate; the value is set at the falling edge and
	// seen by the core and the checker at the next rising edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle);
	end

	// Every result taken at a rising edge is compared with the oldest expectation.
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_error($sformatf("result %0d arrived with no item waiting", results_seen));
			end else begin
				want = pending_results.pop_front();
				if (ir_out !== want.ir_out) begin
					report_error($sformatf("result %0d ir_out: want %0b got %0b",
						results_seen, want.ir_out, ir_out));
				end
				if (phase !== want.phase) begin
					report_error($sformatf("result %0d phase: want %0d got %0d",
						results_seen, want.phase, phase));
				end
				if (capture_done !== want.capture_done) begin
					report_error($sformatf("result %0d capture_done: want %0b got %0b",
						results_seen, want.capture_done, capture_done));
				end
				if (capture_discarded !== want.capture_discarded) begin
					report_error($sformatf("result %0d capture_discarded: want %0b got %0b",
						results_seen, want.capture_discarded, capture_discarded));
				end
				if (segment_count !== want.segment_count) begin
					report_error($sformatf("result %0d segment_count: want %0d got %0d",
						results_seen, want.segment_count, segment_count));
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Sender idles lightly, receiver heavily, so the output buffer fills and in_stall
		// rises. The directed table runs at the reset configuration.
		send_idle = 33;
		recv_idle = 65;
		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].op, directed_rows[i].level,
				directed_rows[i].typed, directed_rows[i].want);
		end
		drain_results();

		// Short timeout, any capture kept, fastest carrier: one capture that is kept
		// and played back unless a rare arm command aborts the replay.
		set_config(256, 1, 1);
		capture_session(4, 6, 1'b0);
		drain_results();

		// Idling swapped. A minimum that a one-segment capture misses, so it is dropped
		// and re-armed, followed by random commands and levels.
		set_config(256, $urandom_range(2, 16), $urandom_range(2, 20));
		send_idle = 65;
		recv_idle = 33;
		capture_session(1, 6, 1'b0);
		noise_burst(10);
		drain_results();

		// No idling on either side: items back to back.
		send_idle = 0;
		recv_idle = 0;
		noise_burst(10);
		drain_results();

		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
